// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, sampled on the rising clock edge and
// disabled while reset is held low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SDTA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define SDTA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/core/sdta_pkg.sv =====
// ----------------------------------------------------------------------------
// sdta_pkg
// Widths, character codes and the pipeline payload type for the signed
// binary to decimal text converter.
// ----------------------------------------------------------------------------
package sdta_pkg;

  localparam int VALUE_WIDTH = 16;

  // decimal digits needed for the largest magnitude, 2^(w-1)
  function automatic int digit_count_f(int w);
    longint unsigned lim;
    longint unsigned p;
    int              n;
    lim = 64'd1 << (w - 1);
    p   = 64'd10;
    n   = 1;
    for (int i = 0; i < 12; i++) begin
      if (p <= lim) begin
        n = n + 1;
        p = p * 64'd10;
      end
    end
    return n;
  endfunction

  localparam int NUM_DIGITS = digit_count_f(VALUE_WIDTH);
  localparam int NDIG_W     = $clog2(NUM_DIGITS + 1);
  localparam int IDX_W      = $clog2(NUM_DIGITS);

  // floor(2^W / 10); quotient estimate is exact or one short
  localparam logic [VALUE_WIDTH-1:0] RECIP_10 =
    VALUE_WIDTH'((64'd1 << VALUE_WIDTH) / 64'd10);
  localparam logic [VALUE_WIDTH-1:0] RADIX = VALUE_WIDTH'(10);

  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  typedef logic [3:0] digit_t;

  typedef struct packed {
    logic                          neg;
    logic [VALUE_WIDTH-1:0]        rem;
    digit_t [NUM_DIGITS-1:0]       digits;
    logic [NDIG_W-1:0]             ndig;
  } stage_t;

endpackage

// ===== rtl/core/sdta_in_if.sv =====
// ----------------------------------------------------------------------------
// sdta_in_if
// Input channel: one signed value per transaction.
// ----------------------------------------------------------------------------
interface sdta_in_if;
  import sdta_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ===== rtl/core/sdta_out_if.sv =====
// ----------------------------------------------------------------------------
// sdta_out_if
// Result channel: one ASCII character per transaction, last flags the end
// of a number.
// ----------------------------------------------------------------------------
interface sdta_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

// ===== rtl/core/signed_decimal_to_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_decimal_to_ascii
// Converts 16-bit two's complement values to decimal ASCII text, one
// character per result transaction, with the final character flagged.
//
//   channel  | direction | payload
//   ---------+-----------+-------------------------------
//   in_ch    | sink      | value (signed, VALUE_WIDTH bits)
//   out_ch   | source    | character (8 bits), last
//
// Stages are the sign stage, one stage per digit and the output holder. A
// value can enter every cycle unless the stages stall; sustained throughput
// is set by the output holder at one character per cycle while out_ch is
// ready, i.e. 1 to 6 characters per value at 16 bits. Reset is synchronous
// active low and clears valid, sign and index bits. A stall on out_ch backs up through the stages without loss.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module signed_decimal_to_ascii (
  input  logic       clk,
  input  logic       rst_n,
  sdta_in_if.sink    in_ch,
  sdta_out_if.source out_ch
);
  import sdta_pkg::*;

  logic   s0_valid_r;
  stage_t s0_data_r;
  stage_t s0_data_nxt;

  logic   st_valid [NUM_DIGITS+1];
  logic   st_ready [NUM_DIGITS+1];
  stage_t st_data  [NUM_DIGITS+1];

  // sign stage: take magnitude, -2^(W-1) wraps to the right unsigned value
  always_comb begin
    s0_data_nxt        = '0;
    s0_data_nxt.neg    = in_ch.value[VALUE_WIDTH-1];
    s0_data_nxt.rem    = in_ch.value[VALUE_WIDTH-1] ?
                         VALUE_WIDTH'(0) - VALUE_WIDTH'(in_ch.value) :
                         VALUE_WIDTH'(in_ch.value);
  end

  assign in_ch.ready = !s0_valid_r || st_ready[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s0_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s0_data_r <= s0_data_nxt;
    end
  end

  assign st_valid[0] = s0_valid_r;
  assign st_data[0]  = s0_data_r;

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_digit
    sdta_digit_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (st_valid[i]),
      .in_ready  (st_ready[i]),
      .in_data   (st_data[i]),
      .out_valid (st_valid[i+1]),
      .out_ready (st_ready[i+1]),
      .out_data  (st_data[i+1])
    );
  end

  sdta_serializer u_ser (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (st_valid[NUM_DIGITS]),
    .in_ready (st_ready[NUM_DIGITS]),
    .in_data  (st_data[NUM_DIGITS]),
    .out_ch   (out_ch)
  );

  `SDTA_ASSERT_IMP(a_minus_not_last, clk, rst_n, out_ch.valid && out_ch.character == CHAR_MINUS, !out_ch.last)
  `SDTA_ASSERT_NXT(a_text_no_gap, clk, rst_n, out_ch.valid && out_ch.ready && !out_ch.last, out_ch.valid)
  `SDTA_ASSERT_NXT(a_sign_stage_hold, clk, rst_n, s0_valid_r && !st_ready[0], s0_valid_r && $stable(s0_data_r))

endmodule

// ===== rtl/core/sdta_digit_stage.sv =====
// ----------------------------------------------------------------------------
// sdta_digit_stage
// One pipeline stage: splits off the lowest decimal digit of the remaining
// magnitude and shifts it into the digit vector.
// ----------------------------------------------------------------------------
module sdta_digit_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  sdta_pkg::stage_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output sdta_pkg::stage_t out_data
);
  import sdta_pkg::*;

  logic                     valid_r;
  stage_t                   data_r;
  stage_t                   data_nxt;
  logic [2*VALUE_WIDTH-1:0] prod;
  logic [VALUE_WIDTH-1:0]   quot;
  logic [VALUE_WIDTH-1:0]   times10;
  logic [VALUE_WIDTH-1:0]   rest;
  digit_t                   digit;

  assign prod    = {{VALUE_WIDTH{1'b0}}, in_data.rem} * {{VALUE_WIDTH{1'b0}}, RECIP_10};
  assign times10 = (prod[2*VALUE_WIDTH-1:VALUE_WIDTH] << 3)
                 + (prod[2*VALUE_WIDTH-1:VALUE_WIDTH] << 1);
  assign rest    = in_data.rem - times10;

  always_comb begin
    if (rest >= RADIX) begin
      quot  = prod[2*VALUE_WIDTH-1:VALUE_WIDTH] + VALUE_WIDTH'(1);
      digit = 4'(rest - RADIX);
    end else begin
      quot  = prod[2*VALUE_WIDTH-1:VALUE_WIDTH];
      digit = 4'(rest);
    end
  end

  always_comb begin
    data_nxt        = in_data;
    data_nxt.rem    = quot;
    data_nxt.digits = {digit, in_data.digits[NUM_DIGITS-1:1]};
    // a nonzero remainder means this digit is significant
    if (in_data.rem != '0) begin
      data_nxt.ndig = in_data.ndig + NDIG_W'(1);
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== rtl/core/sdta_serializer.sv =====
// ----------------------------------------------------------------------------
// sdta_serializer
// Holds one converted number and sends its text one character per
// transaction: optional minus, then significant digits, most significant
// first.
// ----------------------------------------------------------------------------
module sdta_serializer (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  sdta_pkg::stage_t in_data,
  sdta_out_if.source       out_ch
);
  import sdta_pkg::*;

  logic                    busy_r;
  logic                    sign_r;
  logic [IDX_W-1:0]        idx_r;
  digit_t [NUM_DIGITS-1:0] digits_r;
  logic [IDX_W-1:0]        load_idx;

  // zero has no significant digit but still prints one
  assign load_idx = (in_data.ndig == '0) ? '0 : IDX_W'(in_data.ndig - NDIG_W'(1));

  assign out_ch.valid     = busy_r;
  assign out_ch.last      = !sign_r && (idx_r == '0);
  assign out_ch.character = sign_r ? CHAR_MINUS : CHAR_ZERO + {4'b0000, digits_r[idx_r]};

  assign in_ready = !busy_r || (out_ch.ready && out_ch.last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      sign_r <= 1'b0;
      idx_r  <= '0;
    end else if (in_ready) begin
      busy_r <= in_valid;
      if (in_valid) begin
        sign_r <= in_data.neg;
        idx_r  <= load_idx;
      end
    end else if (out_ch.ready) begin
      // non-final character taken
      if (sign_r) begin
        sign_r <= 1'b0;
      end else begin
        idx_r <= idx_r - IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      digits_r <= in_data.digits;
    end
  end

endmodule
